[rtl/mlet_pkg.sv]
`default_nettype none

package mlet_pkg;

  // Width of the reported maximum
  localparam int OUT_W = 49;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_MUL   = 5'b00100,
    ST_CMP   = 5'b01000,
    ST_FIN   = 5'b10000
  } state_t;

endpackage

`default_nettype wire

[rtl/mlet_if.sv]
`default_nettype none

interface mlet_req_if #(
  parameter int DOMAIN_BITS    = 10,
  parameter int SLOPE_BITS     = 32,
  parameter int INTERCEPT_BITS = 48
);
  logic                      valid;
  logic                      ready;
  logic                      opcode;
  logic [SLOPE_BITS-1:0]     line_slope;
  logic [INTERCEPT_BITS-1:0] line_intercept;
  logic [DOMAIN_BITS-1:0]    query_point;

  modport source (output valid, opcode, line_slope, line_intercept, query_point,
                  input ready);
  modport sink   (input valid, opcode, line_slope, line_intercept, query_point,
                  output ready);
endinterface

interface mlet_rsp_if import mlet_pkg::*;;
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] max_value;
  logic             empty_res;

  modport source (output valid, max_value, empty_res, input ready);
  modport sink   (input valid, max_value, empty_res, output ready);
endinterface

`default_nettype wire

[rtl/max_line_envelope_tree_core.sv]
`default_nettype none

// Channel  Dir  Payload                                         Handshake
// req      in   opcode, line_slope, line_intercept, query_point  valid/ready
// rsp      out  max_value, empty_res (one item per query)        valid/ready
//
// An item walks DOMAIN_BITS+1 tree levels; at each level the node memory is read,
// then ST_MUL multiplies and ST_CMP compares. An insert ends early at the
// first empty node. One item is in flight at a time.
// After reset a clearing pass writes zero to every node memory address;
// req.ready stays low until it ends.
// A result waits in the output register while the next item is taken; a query
// that finishes while that register is still full holds until rsp.ready.

module max_line_envelope_tree_core import mlet_pkg::*; #(
  parameter int DOMAIN_BITS    = 10,
  parameter int SLOPE_BITS     = 32,
  parameter int INTERCEPT_BITS = 48
) (
  input wire logic   clk,
  input wire logic   rst,
  mlet_req_if.sink   req,
  mlet_rsp_if.source rsp
);

  localparam int IDX_W  = DOMAIN_BITS + 1;
  localparam int MEM_W  = 1 + SLOPE_BITS + INTERCEPT_BITS;
  localparam int PROD_W = SLOPE_BITS + 1 + DOMAIN_BITS;
  localparam int DIF_W  = INTERCEPT_BITS + 1;
  localparam int VAL_W  = ((PROD_W > DIF_W) ? PROD_W : DIF_W) + 1;
  localparam int EXT_W  = (VAL_W > OUT_W) ? VAL_W : OUT_W;

  localparam logic [IDX_W-1:0]       ROOT    = IDX_W'(1);
  localparam logic [DOMAIN_BITS-1:0] TOP_BIT = {1'b1, {(DOMAIN_BITS-1){1'b0}}};
  localparam logic signed [EXT_W-1:0] SAT_HI =
    {{(EXT_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic signed [EXT_W-1:0] SAT_LO =
    {{(EXT_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

  state_t state;

  // walk registers
  logic [IDX_W-1:0]          idx;
  logic [IDX_W-1:0]          clr_idx;
  logic [DOMAIN_BITS-1:0]    tl;
  logic [DOMAIN_BITS-1:0]    half;
  logic                      query;
  logic [SLOPE_BITS-1:0]     k;
  logic [INTERCEPT_BITS-1:0] b;
  logic [DOMAIN_BITS-1:0]    x;
  logic                      found;
  logic signed [VAL_W-1:0]   best;

  // output register
  logic             res_valid;
  logic [OUT_W-1:0] res_value;
  logic             res_empty;

  // node memory ports
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [MEM_W-1:0] wr_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic [MEM_W-1:0] rd_data;

  logic                      rd_valid;
  logic [SLOPE_BITS-1:0]     rd_slope;
  logic [INTERCEPT_BITS-1:0] rd_icpt;

  logic [DOMAIN_BITS-1:0]  tm;
  logic                    leaf;
  logic                    mid_gt;
  logic                    left_gt;
  logic                    go_left;
  logic [IDX_W-1:0]        idx_next;
  logic signed [VAL_W-1:0] val_mid;
  logic signed [VAL_W-1:0] val_left;
  logic signed [EXT_W-1:0] best_ext;
  logic [OUT_W-1:0]        sat_value;
  logic                    accept;
  logic                    res_load;

  assign accept = req.valid && req.ready;
  assign req.ready = (state == ST_IDLE);

  // finished query moves into the output register once it is free
  assign res_load = (state == ST_FIN) && (!res_valid || rsp.ready);

  assign rsp.valid     = res_valid;
  assign rsp.max_value = res_value;
  assign rsp.empty_res = res_empty;

  assign {rd_valid, rd_slope, rd_icpt} = rd_data;

  // midpoint of the current node; the true value always fits, so wrap is harmless
  assign tm   = tl + half;
  assign leaf = (half == '0);

  // new line strictly above the stored one at the midpoint / left end
  assign mid_gt  = (val_mid > 0);
  assign left_gt = (val_left > 0);

  assign go_left  = query ? ($signed(x) < $signed(tm)) : (left_gt != mid_gt);
  assign idx_next = {idx[IDX_W-2:0], ~go_left};

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_data = {1'b1, k, b};
    rd_en   = 1'b0;
    rd_addr = idx_next;
    unique case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_idx;
        wr_data = '0;
      end
      ST_IDLE: begin
        rd_en   = accept;
        rd_addr = ROOT;
      end
      ST_MUL: begin
        // empty node on insert: take the line here
        wr_en = !query && !rd_valid;
      end
      ST_CMP: begin
        wr_en = !query && mid_gt;
        rd_en = !leaf;
      end
      ST_FIN: begin
      end
      default: begin
      end
    endcase
  end

  // clamp the maximum to the output range
  always_comb begin
    best_ext = EXT_W'(best);
    if (best_ext > SAT_HI) begin
      sat_value = SAT_HI[OUT_W-1:0];
    end else if (best_ext < SAT_LO) begin
      sat_value = SAT_LO[OUT_W-1:0];
    end else begin
      sat_value = best_ext[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_valid && rsp.ready) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + IDX_W'(1);
          if (&clr_idx) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            query <= (req.opcode == OP_QUERY);
            k     <= req.line_slope;
            b     <= req.line_intercept;
            x     <= req.query_point;
            idx   <= ROOT;
            tl    <= TOP_BIT;
            half  <= TOP_BIT;
            found <= 1'b0;
            best  <= '0;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (!query && !rd_valid) begin
            state <= ST_IDLE;
          end else begin
            state <= ST_CMP;
          end
        end
        ST_CMP: begin
          if (query) begin
            if (rd_valid) begin
              found <= 1'b1;
              if (!found || (val_mid > best)) begin
                best <= val_mid;
              end
            end
          end else if (mid_gt) begin
            // swap: the stored line moves on down the tree
            k <= rd_slope;
            b <= rd_icpt;
          end
          if (leaf) begin
            state <= query ? ST_FIN : ST_IDLE;
          end else begin
            idx   <= idx_next;
            tl    <= go_left ? tl : tm;
            half  <= half >> 1;
            state <= ST_MUL;
          end
        end
        ST_FIN: begin
          if (res_load) begin
            res_value <= sat_value;
            res_empty <= !found;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  mlet_node_mem #(
    .ADDR_W (IDX_W),
    .DATA_W (MEM_W)
  ) u_node_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // query evaluates the stored line at x; insert compares both lines at tm and tl
  mlet_eval #(
    .SLOPE_W (SLOPE_BITS),
    .ICPT_W  (INTERCEPT_BITS),
    .PT_W    (DOMAIN_BITS),
    .VAL_W   (VAL_W)
  ) u_eval (
    .clk        (clk),
    .load       (state == ST_MUL),
    .query      (query),
    .new_slope  (k),
    .new_icpt   (b),
    .node_slope (rd_slope),
    .node_icpt  (rd_icpt),
    .pt_mid     (query ? x : tm),
    .pt_left    (tl),
    .val_mid    (val_mid),
    .val_left   (val_left)
  );

endmodule

`default_nettype wire

[rtl/mlet_node_mem.sv]
`default_nettype none

module mlet_node_mem #(
  parameter int ADDR_W = 11,
  parameter int DATA_W = 81
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[rtl/mlet_eval.sv]
`default_nettype none

module mlet_eval #(
  parameter int SLOPE_W = 32,
  parameter int ICPT_W  = 48,
  parameter int PT_W    = 10,
  parameter int VAL_W   = 50
) (
  input  wire logic               clk,
  input  wire logic               load,
  input  wire logic               query,
  input  wire logic [SLOPE_W-1:0] new_slope,
  input  wire logic [ICPT_W-1:0]  new_icpt,
  input  wire logic [SLOPE_W-1:0] node_slope,
  input  wire logic [ICPT_W-1:0]  node_icpt,
  input  wire logic [PT_W-1:0]    pt_mid,
  input  wire logic [PT_W-1:0]    pt_left,
  output logic signed [VAL_W-1:0] val_mid,
  output logic signed [VAL_W-1:0] val_left
);

  localparam int PROD_W = SLOPE_W + 1 + PT_W;

  logic signed [SLOPE_W:0]   op_a;
  logic signed [ICPT_W:0]    op_d;
  logic signed [PROD_W-1:0]  prod_mid;
  logic signed [PROD_W-1:0]  prod_left;
  logic signed [ICPT_W:0]    dsum;

  // Query: stored line itself. Insert: new line minus stored line.
  always_comb begin
    if (query) begin
      op_a = $signed({node_slope[SLOPE_W-1], node_slope});
      op_d = $signed({node_icpt[ICPT_W-1], node_icpt});
    end else begin
      op_a = $signed({new_slope[SLOPE_W-1], new_slope})
           - $signed({node_slope[SLOPE_W-1], node_slope});
      op_d = $signed({new_icpt[ICPT_W-1], new_icpt})
           - $signed({node_icpt[ICPT_W-1], node_icpt});
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prod_mid  <= op_a * $signed(pt_mid);
      prod_left <= op_a * $signed(pt_left);
      dsum      <= op_d;
    end
  end

  assign val_mid  = VAL_W'(prod_mid) + VAL_W'(dsum);
  assign val_left = VAL_W'(prod_left) + VAL_W'(dsum);

endmodule

`default_nettype wire

[rtl/mlet_checker.sv]
`default_nettype none

module mlet_checker import mlet_pkg::*; (
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             req_valid,
  input wire logic             req_ready,
  input wire logic             req_opcode,
  input wire logic             rsp_valid,
  input wire logic             rsp_ready,
  input wire logic [OUT_W-1:0] rsp_max_value,
  input wire logic             rsp_empty
);

  // queries taken whose result has not been taken yet
  logic [1:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending
               + 2'((req_valid && req_ready && (req_opcode == OP_QUERY)) ? 1 : 0)
               - 2'((rsp_valid && rsp_ready) ? 1 : 0);
    end
  end

  ap_reset_quiet: assert property (@(posedge clk)
    rst |=> !req_ready && !rsp_valid)
    else $error("req ready or rsp valid right after reset");

  ap_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_max_value) && $stable(rsp_empty))
    else $error("stalled rsp item changed");

  ap_empty_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_empty |-> rsp_max_value == '0)
    else $error("empty result with nonzero value");

  ap_no_orphan: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pending != 2'd0)
    else $error("rsp item without a pending query");

  ap_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second req item taken while one is in flight");

endmodule

bind max_line_envelope_tree_core mlet_checker u_mlet_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .req_opcode    (req.opcode),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_max_value (rsp.max_value),
  .rsp_empty     (rsp.empty_res)
);

`default_nettype wire
